FILE: sv/hwt_pkg.sv
// Shared types, widths and result codes for the hashed timer wheel.
// No dependencies; every other file of the block refers to this package.
package hwt_pkg;

    localparam int WHEEL_SLOTS_DEF   = 60;
    localparam int TIMER_ENTRIES_DEF = 16;

    // Fixed field widths
    localparam int TIMEOUT_W = 16;
    localparam int DIV_W     = 15;   // magnitude bits of a non-negative timeout
    localparam int REM_W     = 8;    // holds ticks % WHEEL_SLOTS for any legal slot count
    localparam int ROUNDS_W  = 10;
    localparam int KIND_W    = 3;
    localparam int HANDLE_W  = 4;
    localparam int SLOT_W    = 6;

    localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = '1;

    localparam int QUEUE_DEPTH = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOEXP    = 3'd4;

    // Classified operation handed from front to back
    typedef struct packed {
        logic                is_tick;
        logic                reject;
        logic [REM_W-1:0]    rem;
        logic [ROUNDS_W-1:0] rounds;
    } op_t;

    // One result transaction
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot_index;
        logic [ROUNDS_W-1:0] rounds_left;
        logic                last;
    } res_t;

endpackage

FILE: sv/hwt_front.sv
// Front end: accepts input transactions, classifies them and splits an add
// timeout into rounds and slot offset with a reciprocal multiply. Uses hwt_pkg.
module hwt_front #(
    parameter int WHEEL_SLOTS = hwt_pkg::WHEEL_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_mode,
    input  logic [hwt_pkg::TIMEOUT_W-1:0]  in_timeout,
    output logic                           push_valid,
    input  logic                           push_ready,
    output hwt_pkg::op_t                   push_data
);

    localparam int SW    = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int DW    = hwt_pkg::DIV_W;
    localparam int MW    = 2 * DW + 1;
    localparam int SHIFT = DW + SW;
    // exact for every DW-bit dividend: ceil(2^(DW+SW) / WHEEL_SLOTS) fits DW+1 bits
    localparam int RECIP = ((1 << SHIFT) + WHEEL_SLOTS - 1) / WHEEL_SLOTS;
    localparam logic [DW:0]   RECIP_C = (DW+1)'(RECIP);
    localparam logic [DW-1:0] DIVISOR = DW'(WHEEL_SLOTS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_REM  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]       state_reg;
    logic [DW-1:0]    n_reg;
    logic [DW-1:0]    q_reg;
    hwt_pkg::op_t     op_reg;

    logic [MW-1:0]    prod;
    logic [MW-1:0]    quot;
    logic [DW-1:0]    qd;
    logic [DW-1:0]    rem;
    logic [DW-1:0]    magnitude;

    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = op_reg;

    // quotient by reciprocal multiply, then remainder from the registered quotient
    assign prod      = MW'(n_reg) * MW'(RECIP_C);
    assign quot      = prod >> SHIFT;
    assign qd        = q_reg * DIVISOR;
    assign rem       = n_reg - qd;
    assign magnitude = (in_timeout[DW-1:0] == '0) ? DW'(1) : in_timeout[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_mode || in_timeout[hwt_pkg::TIMEOUT_W-1])
                            state_reg <= F_PUSH;
                        else
                            state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    state_reg <= F_REM;
                end
                F_REM:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (push_ready)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            op_reg.is_tick <= in_mode;
            op_reg.reject  <= !in_mode && in_timeout[hwt_pkg::TIMEOUT_W-1];
            op_reg.rem     <= '0;
            op_reg.rounds  <= '0;
            n_reg          <= magnitude;
            q_reg          <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            q_reg <= quot[DW-1:0];
        end
        else if (state_reg == F_REM)
        begin
            op_reg.rem <= hwt_pkg::REM_W'(rem[SW-1:0]);
            // saturate rounds to the field width
            if (q_reg[DW-1:hwt_pkg::ROUNDS_W] != '0)
                op_reg.rounds <= hwt_pkg::ROUNDS_MAX;
            else
                op_reg.rounds <= q_reg[hwt_pkg::ROUNDS_W-1:0];
        end
    end

endmodule

FILE: sv/hwt_queue.sv
// Two-entry queue of classified operations between front and back.
// Uses hwt_pkg for the entry type and depth.
module hwt_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  hwt_pkg::op_t push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output hwt_pkg::op_t pop_data
);

    localparam int PW = $clog2(hwt_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(hwt_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(hwt_pkg::QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(hwt_pkg::QUEUE_DEPTH - 1);

    hwt_pkg::op_t  slots_reg [hwt_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: sv/hwt_back.sv
// Back end: executes adds and ticks against the timer table, scanning one entry per
// cycle while no expiry is held up by the result register, which it holds. Uses hwt_pkg.
module hwt_back #(
    parameter int WHEEL_SLOTS   = hwt_pkg::WHEEL_SLOTS_DEF,
    parameter int TIMER_ENTRIES = hwt_pkg::TIMER_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  hwt_pkg::op_t pop_data,
    output logic         res_valid,
    input  logic         res_ready,
    output hwt_pkg::res_t res
);

    localparam int N   = TIMER_ENTRIES;
    localparam int SW  = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int EW  = (N > 1) ? $clog2(N) : 1;
    localparam int CW  = $clog2(N + 1);
    localparam int RW  = hwt_pkg::ROUNDS_W;
    localparam int MW  = SW + RW;
    localparam logic [SW:0]    SLOTS_W  = (SW+1)'(WHEEL_SLOTS);
    localparam logic [SW-1:0]  SLOT_TOP = SW'(WHEEL_SLOTS - 1);
    localparam logic [EW-1:0]  LAST_IDX = EW'(N - 1);
    localparam logic [CW-1:0]  SCAN_END = CW'(N);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SCAN = 2'd1;
    localparam logic [1:0] B_FIN  = 2'd2;

    logic [1:0]                  state_reg;
    logic                        op_tick_reg;
    logic [SW-1:0]               op_slot_reg;
    logic [RW-1:0]               op_rounds_reg;
    logic [hwt_pkg::KIND_W-1:0]  fin_kind_reg;
    logic [EW-1:0]               fin_handle_reg;
    logic [CW-1:0]               sc_reg;
    logic                        e_vld_reg;
    logic [EW-1:0]               eidx_reg;
    logic [MW-1:0]               rd_data_reg;
    logic                        pend_valid_reg;
    logic [EW-1:0]               pend_handle_reg;
    logic [SW-1:0]               cur_slot_reg;
    logic [N-1:0]                entry_valid_reg;
    logic                        res_valid_reg;
    hwt_pkg::res_t               res_reg;

    // timer table: slot and rounds per entry
    logic [MW-1:0] table_mem [N];

    logic [SW-1:0] rd_slot;
    logic [RW-1:0] rd_rounds;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] add_slot;
    logic          can_emit;
    logic          e_act;
    logic          hit;
    logic          expire;
    logic          dec;
    logic          found;
    logic          stall;
    logic          advance;
    logic          emit_pend;
    logic          fin_emit;
    logic          rd_en;
    logic          mem_we;
    logic [MW-1:0] mem_wdata;
    logic          pop;
    logic [8:0]    slot_wide;
    logic [6:0]    handle_wide;
    logic [6:0]    pend_wide;
    hwt_pkg::res_t res_next;

    assign rd_slot   = rd_data_reg[MW-1:RW];
    assign rd_rounds = rd_data_reg[RW-1:0];

    assign slot_sum = {1'b0, cur_slot_reg} + (SW+1)'(pop_data.rem[SW-1:0]);
    assign add_slot = (slot_sum >= SLOTS_W) ? SW'(slot_sum - SLOTS_W) : slot_sum[SW-1:0];

    assign can_emit  = !res_valid_reg || res_ready;
    assign e_act     = (state_reg == B_SCAN) && e_vld_reg;
    assign hit       = e_act && op_tick_reg && entry_valid_reg[eidx_reg]
                       && (rd_slot == cur_slot_reg);
    assign expire    = hit && (rd_rounds == '0);
    assign dec       = hit && (rd_rounds != '0);
    assign found     = e_act && !op_tick_reg && !entry_valid_reg[eidx_reg];
    assign stall     = expire && pend_valid_reg && !can_emit;
    assign advance   = (state_reg == B_SCAN) && !stall;
    assign emit_pend = advance && expire && pend_valid_reg;
    assign fin_emit  = (state_reg == B_FIN) && can_emit;
    assign rd_en     = advance && (sc_reg < SCAN_END);
    assign mem_we    = advance && (dec || found);
    assign mem_wdata = found ? {op_slot_reg, op_rounds_reg}
                             : {rd_slot, rd_rounds - RW'(1)};
    assign pop       = (state_reg == B_IDLE) && pop_valid;
    assign pop_ready = (state_reg == B_IDLE);

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        slot_wide   = 9'(cur_slot_reg);
        handle_wide = 7'(fin_handle_reg);
        pend_wide   = 7'(pend_handle_reg);
        res_next    = '0;
        if (fin_emit)
        begin
            res_next.last = 1'b1;
            if (op_tick_reg)
            begin
                res_next.kind       = pend_valid_reg ? hwt_pkg::KIND_EXPIRED
                                                     : hwt_pkg::KIND_NOEXP;
                res_next.handle     = pend_wide[hwt_pkg::HANDLE_W-1:0];
                res_next.slot_index = slot_wide[hwt_pkg::SLOT_W-1:0];
            end
            else
            begin
                res_next.kind = fin_kind_reg;
                if (fin_kind_reg == hwt_pkg::KIND_ADDED)
                begin
                    slot_wide              = 9'(op_slot_reg);
                    res_next.handle        = handle_wide[hwt_pkg::HANDLE_W-1:0];
                    res_next.slot_index    = slot_wide[hwt_pkg::SLOT_W-1:0];
                    res_next.rounds_left   = op_rounds_reg;
                end
            end
        end
        else
        begin
            // flush the held expiry; a later one follows in this tick
            res_next.kind       = hwt_pkg::KIND_EXPIRED;
            res_next.handle     = pend_wide[hwt_pkg::HANDLE_W-1:0];
            res_next.slot_index = slot_wide[hwt_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            entry_valid_reg <= '0;
            cur_slot_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            e_vld_reg       <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fin_emit || emit_pend)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        e_vld_reg      <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= pop_data.reject ? B_FIN : B_SCAN;
                    end
                end
                B_SCAN:
                begin
                    if (advance)
                    begin
                        e_vld_reg <= (sc_reg < SCAN_END);
                        if (expire)
                        begin
                            entry_valid_reg[eidx_reg] <= 1'b0;
                            pend_valid_reg            <= 1'b1;
                        end
                        if (found)
                        begin
                            entry_valid_reg[eidx_reg] <= 1'b1;
                            state_reg                 <= B_FIN;
                        end
                        else if (e_act && eidx_reg == LAST_IDX)
                        begin
                            state_reg <= B_FIN;
                        end
                    end
                end
                B_FIN:
                begin
                    if (can_emit)
                    begin
                        if (op_tick_reg)
                            cur_slot_reg <= (cur_slot_reg == SLOT_TOP) ? '0
                                            : cur_slot_reg + SW'(1);
                        pend_valid_reg <= 1'b0;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_emit || emit_pend)
            res_reg <= res_next;

        if (pop)
        begin
            op_tick_reg     <= pop_data.is_tick;
            op_slot_reg     <= add_slot;
            op_rounds_reg   <= pop_data.rounds;
            fin_kind_reg    <= pop_data.reject ? hwt_pkg::KIND_REJECTED : hwt_pkg::KIND_FULL;
            fin_handle_reg  <= '0;
            pend_handle_reg <= '0;
            sc_reg          <= '0;
        end
        else if (advance)
        begin
            if (sc_reg < SCAN_END)
            begin
                sc_reg   <= sc_reg + CW'(1);
                eidx_reg <= sc_reg[EW-1:0];
            end
            if (expire)
                pend_handle_reg <= eidx_reg;
            if (found)
            begin
                fin_kind_reg   <= hwt_pkg::KIND_ADDED;
                fin_handle_reg <= eidx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[eidx_reg] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= table_mem[sc_reg[EW-1:0]];
    end

    // a held expiry exists only while a tick is served
    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> op_tick_reg)
        else $error("held expiry outside a tick");

    // a flushed expiry goes out as a non-final expiry result
    a_flush_kind: assert property (@(posedge clk) disable iff (!rst_n)
        emit_pend |=> (res_valid_reg && res_reg.kind == hwt_pkg::KIND_EXPIRED
                       && !res_reg.last))
        else $error("flushed expiry has wrong kind or last");

    // an allocated entry is live when its add result goes out
    a_add_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FIN && !op_tick_reg && fin_kind_reg == hwt_pkg::KIND_ADDED)
        |-> entry_valid_reg[fin_handle_reg])
        else $error("added entry not marked valid");

    // current slot stays within the wheel
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_slot_reg} < SLOTS_W)
        else $error("current slot out of range");

endmodule

FILE: sv/hashed_timer_wheel_top.sv
// Hashed timer wheel: the back serves one transaction at a time, scanning one entry a cycle
// unless m_tready holds back an expiry. An add passes the reciprocal divide and the queue,
// then scans for the lowest free entry; a tick scans the whole table. The back takes no new
// transaction until it is through with the last one.
// Reset (rst_n, asynchronous, active low) frees all timers through the valid flops
// and sets the current slot to 0; no clearing pass is needed.
module hashed_timer_wheel_top #(
    parameter int WHEEL_SLOTS   = hwt_pkg::WHEEL_SLOTS_DEF,
    parameter int TIMER_ENTRIES = hwt_pkg::TIMER_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] timeout (signed)
    input  logic        s_tuser,   // [0] mode: 0 add, 1 tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] handle, [9:4] slot_index, [19:10] rounds_left,
                                   // [23:20] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // final result of the input transaction
);

    hwt_pkg::op_t  push_data;
    hwt_pkg::op_t  pop_data;
    hwt_pkg::res_t res;
    logic          push_valid;
    logic          push_ready;
    logic          pop_valid;
    logic          pop_ready;

    // Front: classify and divide the timeout into rounds and slot offset
    hwt_front #(
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_timeout (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple front and back so each can stall on its own
    hwt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: allocate, scan and expire timers; owns the result register
    hwt_back #(
        .WHEEL_SLOTS   (WHEEL_SLOTS),
        .TIMER_ENTRIES (TIMER_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result transaction onto the master side
    assign m_tdata = {4'b0000, res.rounds_left, res.slot_index, res.handle};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

FILE: verif/hashed_timer_wheel_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hashed_timer_wheel_top: directed and random add/tick stream.
// It predicts every result with its own wheel model and depends on hwt_pkg and the RTL.
module hashed_timer_wheel_top_tb;

    localparam int SLOTS      = hwt_pkg::WHEEL_SLOTS_DEF;
    localparam int ENTRIES    = hwt_pkg::TIMER_ENTRIES_DEF;
    localparam int STALL_MAX  = 4000;   // cycles with no transaction on either side
    localparam int RAND_ITEMS = 435;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } wheel_op_t;

    typedef struct {
        wheel_op_t   op;
        logic [15:0] timeout;
        bit          drain;     // hold this item until every pending result is out
    } wheel_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [15:0] timeout (signed)
    logic        s_tuser = 1'b0;  // [0] mode: 0 add, 1 tick
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [3:0] handle, [9:4] slot_index, [19:10] rounds_left
    logic [2:0]  m_tuser;         // [2:0] kind
    logic        m_tlast;

    // Stimulus waiting for the driver, and results the wheel still owes us
    wheel_req_t     wheel_reqs[$];
    wheel_req_t     next_req;
    hwt_pkg::res_t  due_results[$];

    // Private copy of the timer table and the wheel position
    logic                         live[ENTRIES];
    logic [hwt_pkg::SLOT_W-1:0]   home_slot[ENTRIES];
    logic [hwt_pkg::ROUNDS_W-1:0] laps_left[ENTRIES];
    int                           cur_slot;

    int err_count;
    int in_count;
    int out_count;
    int stall_cycles;
    int n_added, n_rejected, n_full, n_expired, n_quiet;

    hashed_timer_wheel_top #(
        .WHEEL_SLOTS  (SLOTS),
        .TIMER_ENTRIES(ENTRIES)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_fault(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_fault($sformatf("%s got %0d, expected %0d (result %0d)",
                                   name, got, want, out_count));
    endtask

    // Work out the results of one accepted transaction and queue them in order.
    function automatic void predict_wheel(input wheel_op_t op, input logic [15:0] tmo);
        hwt_pkg::res_t r;
        hwt_pkg::res_t burst[$];
        int   free_idx;
        int   ticks;
        int   laps;
        int   served;
        r = '0;
        r.last = 1'b1;
        if (op == OP_ADD)
        begin
            if (tmo[15])
                r.kind = hwt_pkg::KIND_REJECTED;
            else
            begin
                // a zero timeout still waits one tick
                ticks = (tmo == 16'd0) ? 1 : int'(tmo);
                laps  = ticks / SLOTS;
                if (laps > int'(hwt_pkg::ROUNDS_MAX))
                    laps = int'(hwt_pkg::ROUNDS_MAX);
                free_idx = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (!live[i] && free_idx < 0)
                        free_idx = i;
                if (free_idx < 0)
                    r.kind = hwt_pkg::KIND_FULL;
                else
                begin
                    live[free_idx]      = 1'b1;
                    home_slot[free_idx] =
                        hwt_pkg::SLOT_W'((cur_slot + ticks % SLOTS) % SLOTS);
                    laps_left[free_idx] = hwt_pkg::ROUNDS_W'(laps);
                    r.kind        = hwt_pkg::KIND_ADDED;
                    r.handle      = hwt_pkg::HANDLE_W'(free_idx);
                    r.slot_index  = home_slot[free_idx];
                    r.rounds_left = laps_left[free_idx];
                end
            end
            due_results.push_back(r);
        end
        else
        begin
            served = cur_slot;
            // serve the slot: burn a lap or expire, lowest entry first
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (live[i] && home_slot[i] == hwt_pkg::SLOT_W'(served))
                begin
                    if (laps_left[i] != '0)
                        laps_left[i]--;
                    else
                    begin
                        live[i] = 1'b0;
                        r = '0;
                        r.kind       = hwt_pkg::KIND_EXPIRED;
                        r.handle     = hwt_pkg::HANDLE_W'(i);
                        r.slot_index = hwt_pkg::SLOT_W'(served);
                        burst.push_back(r);
                    end
                end
            end
            cur_slot = (served + 1) % SLOTS;
            if (burst.size() == 0)
            begin
                r = '0;
                r.kind       = hwt_pkg::KIND_NOEXP;
                r.slot_index = hwt_pkg::SLOT_W'(served);
                r.last       = 1'b1;
                burst.push_back(r);
            end
            else
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                due_results.push_back(burst[i]);
        end
    endfunction

    // Random back-off, about one cycle in four; no idling while the quiet window is open.
    function automatic bit take_break();
        if (in_count >= 150 && in_count < 260)
            return 1'b0;
        return $urandom_range(99) < 25;
    endfunction

    function automatic void push_add(input int tmo, input bit drain = 1'b0);
        wheel_req_t q;
        q.op      = OP_ADD;
        q.timeout = tmo[15:0];
        q.drain   = drain;
        wheel_reqs.push_back(q);
    endfunction

    function automatic void push_tick(input bit drain = 1'b0);
        wheel_req_t q;
        q.op      = OP_TICK;
        q.timeout = 16'($urandom);   // ignored by the wheel, toggled anyway
        q.drain   = drain;
        wheel_reqs.push_back(q);
    endfunction

    // Driver: predict each accepted transaction, then present the next one or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_wheel(wheel_op_t'(s_tuser), s_tdata);
                in_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (wheel_reqs.size() != 0 && !take_break() &&
                    !(wheel_reqs[0].drain && due_results.size() != 0))
                begin
                    next_req = wheel_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.timeout;
                    s_tuser  <= next_req.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                    report_fault($sformatf("unexpected result kind %0d handle %0d slot %0d",
                                           m_tuser, m_tdata[3:0], m_tdata[9:4]));
                else
                begin
                    check_field("kind", m_tuser, due_results[0].kind);
                    check_field("handle", m_tdata[3:0], due_results[0].handle);
                    check_field("slot_index", m_tdata[9:4], due_results[0].slot_index);
                    check_field("rounds_left", m_tdata[19:10], due_results[0].rounds_left);
                    check_field("last", m_tlast, due_results[0].last);
                    void'(due_results.pop_front());
                end
                case (m_tuser)
                    hwt_pkg::KIND_ADDED:    n_added++;
                    hwt_pkg::KIND_REJECTED: n_rejected++;
                    hwt_pkg::KIND_FULL:     n_full++;
                    hwt_pkg::KIND_EXPIRED:  n_expired++;
                    default:                n_quiet++;
                endcase
                out_count++;
            end
            m_tready <= !take_break();
        end
    end

    // Watchdog: end the run if neither side moves a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                         stall_cycles, due_results.size());
                $display("hashed_timer_wheel_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        int tmo;
        err_count    = 0;
        in_count     = 0;
        out_count    = 0;
        stall_cycles = 0;
        n_added = 0; n_rejected = 0; n_full = 0; n_expired = 0; n_quiet = 0;
        cur_slot = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            live[i]      = 1'b0;
            home_slot[i] = '0;
            laps_left[i] = '0;
        end

        // Directed part: zero timeout (one tick), one tick, slot wrap, whole laps,
        // negative extremes, the largest timeout, a tick with nothing due, a tick
        // expiring two timers, then fill the table and overflow it.
        push_add(0);
        push_add(1);
        push_add(59);
        push_add(60);
        push_add(120);
        push_add(-1);
        push_add(-32768);
        push_add(32767);
        push_tick();          // slot 0: burn a lap on two timers, nothing expires
        push_tick();          // slot 1: two expiries, ascending handles
        for (int i = 0; i < 12; i++)
            push_add(1);      // refill every free entry, all in one slot
        push_add(5);          // table full
        push_tick();
        push_tick();          // a long burst of expiries from a single slot

        // Random part: mostly short timers so the table churns between free and full,
        // some multi-lap timers, negatives, and a rare huge timer that never expires.
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
                push_tick(i % 97 == 0);
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    tmo = $urandom_range(40);
                else if (pick < 85)
                    tmo = $urandom_range(150);
                else if (pick < 96)
                    tmo = 32'hFFFF_8000 | $urandom_range(16'h7FFF);
                else
                    tmo = $urandom_range(16'h7FFF);
                push_add(tmo, i % 97 == 0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait for all stimulus to go in and every prediction to come out.
        while (wheel_reqs.size() != 0 || s_tvalid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d inputs and %0d results: %0d added, %0d rejected, %0d table full",
                 in_count, out_count, n_added, n_rejected, n_full);
        $display("  %0d timer expiries and %0d ticks with nothing due", n_expired, n_quiet);
        if (err_count == 0)
            $display("hashed_timer_wheel_top regression: pass");
        else
            $display("hashed_timer_wheel_top regression: fail");
        $finish;
    end

endmodule
